>>> sv/least_frequent_value_finder_assert.svh
// Assertion macros of the least frequent value finder.
`ifndef LEAST_FREQUENT_VALUE_FINDER_ASSERT_SVH
`define LEAST_FREQUENT_VALUE_FINDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LFVF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lfvf assertion failed");

// Next-cycle implication, disabled while reset is held.
`define LFVF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lfvf assertion failed");

`endif

>>> sv/lfvf_pkg.sv
// Shared constants and types of the least frequent value finder.
package lfvf_pkg;

    localparam int MAX_ITEMS  = 128;
    localparam int VALUE_BITS = 31;
    localparam int COUNT_BITS = 8;
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

    localparam int S_TDATA_W = ((VALUE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VALUE_BITS + COUNT_BITS + 7) / 8) * 8;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        S_LOAD  = 2'b01,
        S_DRAIN = 2'b10
    } t_state;

    // Broadcast controls from the sequencer to every cell.
    typedef struct packed {
        logic alloc;   // shift up, new distinct value enters cell 0
        logic inc;     // matching cell counts one more occurrence
        logic drain;   // shift down toward the reducer
    } t_cell_ctl;

endpackage

>>> sv/lfvf_cell.sv
// One cell of the chain: a distinct value and its occurrence count.
module lfvf_cell (
    input  logic                             i_clk,
    input  lfvf_pkg::t_cell_ctl              i_ctl,
    input  logic                             i_loaded,
    input  logic [lfvf_pkg::VALUE_BITS-1:0]  i_value,
    input  logic [lfvf_pkg::VALUE_BITS-1:0]  i_prev_value,
    input  logic [lfvf_pkg::COUNT_BITS-1:0]  i_prev_count,
    input  logic [lfvf_pkg::VALUE_BITS-1:0]  i_next_value,
    input  logic [lfvf_pkg::COUNT_BITS-1:0]  i_next_count,
    output logic [lfvf_pkg::VALUE_BITS-1:0]  o_value,
    output logic [lfvf_pkg::COUNT_BITS-1:0]  o_count,
    output logic                             o_match
);
    import lfvf_pkg::*;

    logic [VALUE_BITS-1:0] r_value;
    logic [COUNT_BITS-1:0] r_count;
    logic [VALUE_BITS-1:0] n_value;
    logic [COUNT_BITS-1:0] n_count;

    // Compare the broadcast word against the held value
    assign o_match = i_loaded && (r_value == i_value);

    // Shift up on allocate, shift down on drain, count up on a hit
    always_comb begin
        n_value = r_value;
        n_count = r_count;
        if (i_ctl.drain) begin
            n_value = i_next_value;
            n_count = i_next_count;
        end else if (i_ctl.alloc) begin
            n_value = i_prev_value;
            n_count = i_prev_count;
        end else if (i_ctl.inc && o_match && (r_count != COUNT_MAX)) begin
            n_count = r_count + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_count <= n_count;
    end

    assign o_value = r_value;
    assign o_count = r_count;

endmodule

>>> sv/lfvf_reducer.sv
// Running minimum over (count, value) pairs drained from the chain.
module lfvf_reducer (
    input  logic                             i_clk,
    input  logic                             i_step,
    input  logic                             i_start,
    input  logic [lfvf_pkg::VALUE_BITS-1:0]  i_value,
    input  logic [lfvf_pkg::COUNT_BITS-1:0]  i_count,
    output logic [lfvf_pkg::VALUE_BITS-1:0]  o_value,
    output logic [lfvf_pkg::COUNT_BITS-1:0]  o_count
);
    import lfvf_pkg::*;

    logic [VALUE_BITS-1:0] r_best_value;
    logic [COUNT_BITS-1:0] r_best_count;
    logic                  w_take;

    // Fewer occurrences wins, smaller value breaks a tie
    always_comb begin
        w_take = i_start || (i_count < r_best_count) ||
                 ((i_count == r_best_count) && (i_value < r_best_value));
        o_value = w_take ? i_value : r_best_value;
        o_count = w_take ? i_count : r_best_count;
    end

    // Hold the best pair seen so far
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_best_value <= o_value;
            r_best_count <= o_count;
        end
    end

endmodule

>>> sv/least_frequent_value_finder.sv
// Load: one word per cycle; each distinct value sits in one cell of a chain.
// After the word marked tlast, the k cells holding distinct values drain into
// a reducer, one cell per cycle; the result is registered at the last drain step.
// Input is held off during the drain, and the last drain step waits while the
// previous result is still unread.
// Synchronous active-low reset empties the chain and clears the output valid flag.
`include "least_frequent_value_finder_assert.svh"

module least_frequent_value_finder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [lfvf_pkg::S_TDATA_W-1:0]  i_s_tdata,   // value, zero pad
    input  logic                            i_s_tlast,   // last_item
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [lfvf_pkg::M_TDATA_W-1:0]  o_m_tdata,   // least_value, least_count, zero pad
    output logic                            o_m_tuser    // overflowed
);
    import lfvf_pkg::*;

    // Chain wiring
    logic [VALUE_BITS-1:0] w_value      [MAX_ITEMS];
    logic [COUNT_BITS-1:0] w_count      [MAX_ITEMS];
    logic [VALUE_BITS-1:0] w_prev_value [MAX_ITEMS];
    logic [COUNT_BITS-1:0] w_prev_count [MAX_ITEMS];
    logic [VALUE_BITS-1:0] w_next_value [MAX_ITEMS];
    logic [COUNT_BITS-1:0] w_next_count [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]  w_match;
    logic [MAX_ITEMS-1:0]  w_loaded;
    logic [VALUE_BITS-1:0] w_in_value;
    t_cell_ctl             w_ctl;

    // Control state
    t_state           r_state,    n_state;
    logic [CNT_W-1:0] r_items,    n_items;
    logic [CNT_W-1:0] r_distinct, n_distinct;
    logic [CNT_W-1:0] r_left,     n_left;
    logic             r_ovf,      n_ovf;
    logic             r_first,    n_first;
    logic             r_m_valid,  n_m_valid;

    // Payload
    logic                  r_set_ovf;
    logic                  r_res_ovf;
    logic [VALUE_BITS-1:0] r_m_value;
    logic [COUNT_BITS-1:0] r_m_count;

    logic                  w_accept;
    logic                  w_full;
    logic                  w_any_match;
    logic                  w_out_free;
    logic                  w_drain_step;
    logic                  w_done;
    logic [VALUE_BITS-1:0] w_best_value;
    logic [COUNT_BITS-1:0] w_best_count;

    assign w_in_value = i_s_tdata[VALUE_BITS-1:0];
    assign o_s_tready = (r_state == S_LOAD);

    // Build the chain of cells
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_prev_value[g] = w_in_value;
            assign w_prev_count[g] = COUNT_BITS'(1);
        end else begin : g_body
            assign w_prev_value[g] = w_value[g-1];
            assign w_prev_count[g] = w_count[g-1];
        end
        if (g == MAX_ITEMS - 1) begin : g_tail
            assign w_next_value[g] = '0;
            assign w_next_count[g] = '0;
        end else begin : g_mid
            assign w_next_value[g] = w_value[g+1];
            assign w_next_count[g] = w_count[g+1];
        end
        assign w_loaded[g] = (CNT_W'(g) < r_distinct);

        lfvf_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_loaded     (w_loaded[g]),
            .i_value      (w_in_value),
            .i_prev_value (w_prev_value[g]),
            .i_prev_count (w_prev_count[g]),
            .i_next_value (w_next_value[g]),
            .i_next_count (w_next_count[g]),
            .o_value      (w_value[g]),
            .o_count      (w_count[g]),
            .o_match      (w_match[g])
        );
    end

    lfvf_reducer u_reducer (
        .i_clk   (i_clk),
        .i_step  (w_drain_step),
        .i_start (r_first),
        .i_value (w_value[0]),
        .i_count (w_count[0]),
        .o_value (w_best_value),
        .o_count (w_best_count)
    );

    // Decode the word and the drain step
    always_comb begin
        w_accept     = i_s_tvalid && o_s_tready;
        w_full       = (r_items == CNT_W'(MAX_ITEMS));
        w_any_match  = |w_match;
        w_out_free   = !r_m_valid || i_m_tready;
        w_drain_step = (r_state == S_DRAIN) && ((r_left != CNT_W'(1)) || w_out_free);
        w_done       = w_drain_step && (r_left == CNT_W'(1));
        w_ctl.alloc  = w_accept && !w_full && !w_any_match;
        w_ctl.inc    = w_accept && !w_full && w_any_match;
        w_ctl.drain  = w_drain_step;
    end

    // Sequence load and drain
    always_comb begin
        n_state    = r_state;
        n_items    = r_items;
        n_distinct = r_distinct + CNT_W'(w_ctl.alloc);
        n_left     = r_left;
        n_ovf      = r_ovf;
        n_first    = r_first;
        n_m_valid  = r_m_valid;

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_items = r_items + CNT_W'(1);
                    end
                    if (i_s_tlast) begin
                        n_state    = S_DRAIN;
                        n_left     = n_distinct;
                        n_first    = 1'b1;
                        n_items    = '0;
                        n_distinct = '0;
                        n_ovf      = 1'b0;
                    end
                end
            end
            S_DRAIN: begin
                if (w_drain_step) begin
                    n_first = 1'b0;
                    n_left  = r_left - CNT_W'(1);
                end
                if (w_done) begin
                    n_state   = S_LOAD;
                    n_m_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_items    <= '0;
            r_distinct <= '0;
            r_left     <= '0;
            r_ovf      <= 1'b0;
            r_first    <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_items    <= n_items;
            r_distinct <= n_distinct;
            r_left     <= n_left;
            r_ovf      <= n_ovf;
            r_first    <= n_first;
            r_m_valid  <= n_m_valid;
        end
    end

    // Hold the overflow flag of the draining set; move it out with the result word
    always_ff @(posedge i_clk) begin
        if (w_accept && i_s_tlast) begin
            r_set_ovf <= r_ovf || w_full;
        end
        if (w_done) begin
            r_m_value <= w_best_value;
            r_m_count <= w_best_count;
            r_res_ovf <= r_set_ovf;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = M_TDATA_W'({r_m_count, r_m_value});
    assign o_m_tuser  = r_res_ovf;

    `LFVF_ASSERT_NOW(a_result_after_drain, i_clk, i_rst_n, $rose(o_m_tvalid), $past(r_state == S_DRAIN))
    `LFVF_ASSERT_NOW(a_drain_has_cells, i_clk, i_rst_n, r_state == S_DRAIN, r_left != '0)
    `LFVF_ASSERT_NOW(a_distinct_le_items, i_clk, i_rst_n, r_state == S_LOAD, r_distinct <= r_items)
    `LFVF_ASSERT_NOW(a_count_nonzero, i_clk, i_rst_n, o_m_tvalid, r_m_count != '0)
    `LFVF_ASSERT_NEXT(a_last_starts_drain, i_clk, i_rst_n, w_accept && i_s_tlast, r_state == S_DRAIN)

endmodule
